@@ design/phbp_pkg.sv @@
// Shared types, codes and helper functions for the pipeline hazard and branch predictor block.
package phbp_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int STAGE_COUNT       = 7;

  localparam logic [7:0] NO_REG       = 8'd255;
  localparam logic [1:0] SQUASH_SLOTS = 2'd3;

  // stage positions
  localparam int ST_IF1  = 0;
  localparam int ST_IF2  = 1;
  localparam int ST_ID   = 2;
  localparam int ST_EX   = 3;
  localparam int ST_MEM1 = 4;
  localparam int ST_MEM2 = 5;
  localparam int ST_WB   = 6;

  // instruction kinds
  localparam logic [3:0] K_NOP    = 4'd0;
  localparam logic [3:0] K_RTYPE  = 4'd1;
  localparam logic [3:0] K_ITYPE  = 4'd2;
  localparam logic [3:0] K_LOAD   = 4'd3;
  localparam logic [3:0] K_STORE  = 4'd4;
  localparam logic [3:0] K_BRANCH = 4'd5;
  localparam logic [3:0] K_JTYPE  = 4'd6;
  localparam logic [3:0] K_SPEC   = 4'd7;
  localparam logic [3:0] K_JRTYPE = 4'd8;

  // slot classes
  localparam logic [1:0] C_BUBBLE = 2'd0;
  localparam logic [1:0] C_SQUASH = 2'd1;
  localparam logic [1:0] C_REAL   = 2'd2;

  // predictor modes
  localparam logic [1:0] MODE_NT   = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_TWO  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  cls;
    logic [3:0]  kind;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  dr;
    logic [31:0] pc;
    logic [31:0] addr;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic bubble;
  } cell_ctl_t;

  typedef struct packed {
    logic        is_branch;
    logic        taken;
    logic [31:0] addr;
  } pred_req_t;

  typedef struct packed {
    slot_t slot;
    logic  pending_taken;
  } result_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [1:0]  ctr;
  } pred_ent_t;

  function automatic slot_t make_empty(logic [1:0] cls);
    slot_t s;
    s.cls  = cls;
    s.kind = K_NOP;
    s.sa   = NO_REG;
    s.sb   = NO_REG;
    s.dr   = (cls == C_SQUASH) ? 8'd0 : NO_REG;
    s.pc   = 32'd0;
    s.addr = 32'd0;
    return s;
  endfunction

  // load in ld writes a register that the decode slot reads
  function automatic logic load_blocks(slot_t ld, slot_t id);
    logic hit;
    hit = 1'b0;
    if (ld.kind == K_LOAD) begin
      if (id.kind == K_RTYPE || id.kind == K_STORE || id.kind == K_BRANCH) begin
        hit = (ld.dr == id.sa) || (ld.dr == id.sb);
      end else if (id.kind == K_ITYPE || id.kind == K_LOAD || id.kind == K_JRTYPE) begin
        hit = (ld.dr == id.sa);
      end
    end
    return hit;
  endfunction

endpackage

@@ design/phbp_if.sv @@
// Channel interfaces: pending instruction requests, retire results and mode writes.
interface phbp_in_if;
  logic        valid;
  logic        ready;
  logic        pending_valid;
  logic [3:0]  instr_kind;
  logic [7:0]  src_reg_a;
  logic [7:0]  src_reg_b;
  logic [7:0]  dest_reg;
  logic [31:0] instr_pc;
  logic [31:0] instr_addr;

  modport source(output valid, pending_valid, instr_kind, src_reg_a, src_reg_b, dest_reg,
                 instr_pc, instr_addr, input ready);
  modport sink(input valid, pending_valid, instr_kind, src_reg_a, src_reg_b, dest_reg,
               instr_pc, instr_addr, output ready);
endinterface

interface phbp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  retire_class;
  logic [3:0]  retire_kind;
  logic [7:0]  retire_src_a;
  logic [7:0]  retire_src_b;
  logic [7:0]  retire_dest;
  logic [31:0] retire_pc;
  logic [31:0] retire_addr;
  logic        pending_taken;

  modport source(output valid, retire_class, retire_kind, retire_src_a, retire_src_b,
                 retire_dest, retire_pc, retire_addr, pending_taken, input ready);
  modport sink(input valid, retire_class, retire_kind, retire_src_a, retire_src_b,
               retire_dest, retire_pc, retire_addr, pending_taken, output ready);
endinterface

interface phbp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] predict_mode;

  modport source(output valid, predict_mode, input ready);
  modport sink(input valid, predict_mode, output ready);
endinterface

@@ design/phbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module phbp_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/phbp_cell.sv @@
// One pipeline stage cell: holds a slot, takes its neighbor's slot or a bubble.
module phbp_cell import phbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tick,
  input  cell_ctl_t ctl,
  input  slot_t     prev,
  output slot_t     slot_nxt,
  output slot_t     slot
);

  slot_t slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (tick) begin
      priority if (ctl.bubble) begin
        slot_nxt = make_empty(C_BUBBLE);
      end else if (ctl.shift) begin
        slot_nxt = prev;
      end else begin
        // hold
        slot_nxt = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= make_empty(C_BUBBLE);
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule

@@ design/phbp_pred.sv @@
// Tagged branch predictor table with clearing sweep and write bypass.
module phbp_pred import phbp_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  mode,
  input  logic        tick,
  input  pred_req_t   req,
  input  logic [31:0] look_addr,
  output logic        mispredict,
  output logic        clearing
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int EW = $bits(pred_ent_t);

  function automatic logic [IW-1:0] idx_of(logic [31:0] a);
    return IW'((a >> 3) % TABLE_ENTRIES);
  endfunction

  logic            clearing_r;
  logic [IW-1:0]   clr_idx_r;
  logic            byp_r;
  pred_ent_t       byp_data_r;
  logic [EW-1:0]   ram_q;
  pred_ent_t       ent;
  pred_ent_t       upd_ent;
  logic            upd;
  logic            mis;
  logic            hit;
  logic            we;
  logic [IW-1:0]   waddr;
  logic [IW-1:0]   raddr;
  pred_ent_t       wdata;

  assign ent = byp_r ? byp_data_r : pred_ent_t'(ram_q);
  assign hit = (ent.tag == req.addr);

  always_comb begin
    mis     = 1'b0;
    upd     = 1'b0;
    upd_ent = ent;
    unique case (mode)
      MODE_NT: begin
        mis = req.taken;
      end
      MODE_ONE: begin
        if (hit) begin
          if ({1'b0, req.taken} != ent.ctr) begin
            mis         = 1'b1;
            upd         = 1'b1;
            upd_ent.ctr = {1'b0, req.taken};
          end
        end else begin
          upd         = 1'b1;
          upd_ent.tag = req.addr;
          upd_ent.ctr = {1'b0, req.taken};
          mis         = req.taken;
        end
      end
      MODE_TWO: begin
        upd = 1'b1;
        if (hit) begin
          unique case (ent.ctr)
            2'd0: begin
              if (req.taken) begin
                upd_ent.ctr = 2'd1;
                mis         = 1'b1;
              end
            end
            2'd1: begin
              upd_ent.ctr = req.taken ? 2'd3 : 2'd0;
              mis         = req.taken;
            end
            2'd2: begin
              upd_ent.ctr = req.taken ? 2'd3 : 2'd0;
              mis         = !req.taken;
            end
            default: begin
              if (!req.taken) begin
                upd_ent.ctr = 2'd2;
                mis         = 1'b1;
              end
            end
          endcase
        end else begin
          upd_ent.tag = req.addr;
          upd_ent.ctr = req.taken ? 2'd3 : 2'd0;
          mis         = req.taken;
        end
      end
      default: begin
      end
    endcase
  end

  assign mispredict = req.is_branch && mis;

  always_comb begin
    we    = clearing_r || (tick && req.is_branch && upd);
    waddr = clearing_r ? clr_idx_r : idx_of(req.addr);
    wdata = clearing_r ? pred_ent_t'('0) : upd_ent;
    raddr = idx_of(look_addr);
  end

  phbp_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(EW'(wdata)),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // same-cycle write to the entry being read: forward the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= we && (waddr == raddr);
    end
    byp_data_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      if (clr_idx_r == IW'(TABLE_ENTRIES - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  assign clearing = clearing_r;

endmodule

@@ design/phbp_oq.sv @@
// Two-entry result queue between the pipeline and the result channel.
module phbp_oq import phbp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    head_valid,
  output result_t head
);

  result_t    ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rp_r];
  assign cnt_nxt    = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

@@ design/pipeline_hazard_branch_predictor_core.sv @@
// Top level: seven-cell pipeline model with hazard detection and branch prediction.
//
//   channel  direction  handshake        payload
//   in_ch    sink       valid / ready    one clock tick: pending instruction or bubble
//   out_ch   source     valid / ready    writeback slot and pending_taken
//   cfg_ch   sink       valid / ready    predict_mode, ready always high
//
// One request is taken per cycle while in_ch.ready is high; each pushes one result into a
// two-entry result queue, and in_ch.ready drops while that queue is full.
// After reset the predictor table is swept clear, one entry per cycle, through all
// TABLE_ENTRIES entries; in_ch.ready stays low during the sweep.
// Reset is synchronous, active low; cells return to bubbles, mode to zero.
module pipeline_hazard_branch_predictor_core import phbp_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  phbp_in_if.sink     in_ch,
  phbp_out_if.source  out_ch,
  phbp_cfg_if.sink    cfg_ch
);

  logic [1:0] mode_r;
  logic [1:0] squash_left_r;
  logic [1:0] squash_left_nxt;

  slot_t      stage_q [STAGE_COUNT];
  slot_t      stage_d [STAGE_COUNT];
  slot_t      prev_in [STAGE_COUNT];
  cell_ctl_t  ctl     [STAGE_COUNT];

  slot_t      pend;
  slot_t      front;
  logic       tick;
  logic       clearing;
  logic       q_full;
  logic       q_valid;
  result_t    q_head;
  logic       pop;
  logic       structural;
  logic       ld_ex;
  logic       ld_mem;
  logic       st_ex;
  logic       st_mem;
  logic       stall;
  logic       mispredict;
  logic       squash;
  logic       pend_taken;
  pred_req_t  preq;
  logic [31:0] look_addr;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NT;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.predict_mode;
    end
  end

  assign in_ch.ready = !q_full && !clearing;
  assign tick        = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_ch.pending_valid) begin
      pend.cls  = C_REAL;
      pend.kind = in_ch.instr_kind;
      pend.sa   = in_ch.src_reg_a;
      pend.sb   = in_ch.src_reg_b;
      pend.dr   = in_ch.dest_reg;
      pend.pc   = in_ch.instr_pc;
      pend.addr = in_ch.instr_addr;
    end else begin
      pend = make_empty(C_BUBBLE);
    end
  end

  // hazards on the decode slot
  always_comb begin
    structural = 1'b0;
    if (stage_q[ST_WB].kind == K_RTYPE || stage_q[ST_WB].kind == K_ITYPE ||
        stage_q[ST_WB].kind == K_LOAD) begin
      structural = (stage_q[ST_ID].kind == K_RTYPE) ||
                   (stage_q[ST_ID].kind == K_ITYPE && stage_q[ST_ID].sa != NO_REG) ||
                   (stage_q[ST_ID].kind == K_LOAD) ||
                   (stage_q[ST_ID].kind == K_STORE) ||
                   (stage_q[ST_ID].kind == K_BRANCH) ||
                   (stage_q[ST_ID].kind == K_JRTYPE);
    end
    ld_ex  = load_blocks(stage_q[ST_EX], stage_q[ST_ID]);
    ld_mem = load_blocks(stage_q[ST_MEM1], stage_q[ST_ID]);
    // a load in MEM1 wins over EX and over the structural case
    st_mem = ld_mem;
    st_ex  = !ld_mem && (ld_ex || structural);
    stall  = st_mem || st_ex;
  end

  // branch in IF1 resolves against the pending pc
  always_comb begin
    preq.is_branch = (stage_q[ST_IF1].kind == K_BRANCH);
    preq.taken     = (stage_q[ST_IF1].addr == pend.pc);
    preq.addr      = stage_q[ST_IF1].addr;
  end

  assign look_addr = tick ? stage_d[ST_IF1].addr : stage_q[ST_IF1].addr;

  phbp_pred #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_pred (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .tick      (tick),
    .req       (preq),
    .look_addr (look_addr),
    .mispredict(mispredict),
    .clearing  (clearing)
  );

  assign squash     = mispredict || (squash_left_r != 2'd0);
  assign pend_taken = in_ch.pending_valid && !squash && !stall;
  assign front      = squash ? make_empty(C_SQUASH) : pend;

  always_comb begin
    priority if (mispredict) begin
      squash_left_nxt = SQUASH_SLOTS - 2'd1;
    end else if (squash_left_r != 2'd0) begin
      squash_left_nxt = squash_left_r - 2'd1;
    end else begin
      squash_left_nxt = squash_left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      squash_left_r <= 2'd0;
    end else if (tick) begin
      squash_left_r <= squash_left_nxt;
    end
  end

  // per-cell controls: stalls hold the front and drop a bubble behind them
  always_comb begin
    for (int i = 0; i < STAGE_COUNT; i++) begin
      ctl[i].shift  = 1'b1;
      ctl[i].bubble = 1'b0;
    end
    ctl[ST_MEM1].bubble = st_mem;
    ctl[ST_EX].bubble   = st_ex;
    ctl[ST_EX].shift    = !st_mem;
    ctl[ST_ID].shift    = !stall;
    ctl[ST_IF2].shift   = !stall;
    ctl[ST_IF1].shift   = squash || !stall;
  end

  always_comb begin
    prev_in[ST_IF1] = front;
    for (int i = 1; i < STAGE_COUNT; i++) begin
      prev_in[i] = stage_q[i-1];
    end
  end

  for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_cell
    phbp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick    (tick),
      .ctl     (ctl[g]),
      .prev    (prev_in[g]),
      .slot_nxt(stage_d[g]),
      .slot    (stage_q[g])
    );
  end

  assign pop = q_valid && out_ch.ready;

  phbp_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .push_data ('{slot: stage_q[ST_WB], pending_taken: pend_taken}),
    .pop       (pop),
    .full      (q_full),
    .head_valid(q_valid),
    .head      (q_head)
  );

  assign out_ch.valid         = q_valid;
  assign out_ch.retire_class  = q_head.slot.cls;
  assign out_ch.retire_kind   = q_head.slot.kind;
  assign out_ch.retire_src_a  = q_head.slot.sa;
  assign out_ch.retire_src_b  = q_head.slot.sb;
  assign out_ch.retire_dest   = q_head.slot.dr;
  assign out_ch.retire_pc     = q_head.slot.pc;
  assign out_ch.retire_addr   = q_head.slot.addr;
  assign out_ch.pending_taken = q_head.pending_taken;

  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ch.ready)
    else $error("request taken during table clear");

  a_squash_reload: assert property (@(posedge clk) disable iff (!rst_n)
    tick && mispredict |=> squash_left_r == SQUASH_SLOTS - 2'd1)
    else $error("squash count not reloaded on mispredict");

  a_squash_fills_if1: assert property (@(posedge clk) disable iff (!rst_n)
    tick && squash |=> stage_q[ST_IF1].cls == C_SQUASH)
    else $error("IF1 not squashed");

  a_taken_enters_if1: assert property (@(posedge clk) disable iff (!rst_n)
    tick && pend_taken |=> stage_q[ST_IF1] == $past(pend))
    else $error("taken request missing from IF1");

endmodule

@@ sim/pipeline_hazard_branch_predictor_core_tb.sv @@
// Testbench for the pipeline hazard and branch predictor core: program-like and noise ticks.
`timescale 1ns / 1ps

module pipeline_hazard_branch_predictor_core_tb import phbp_pkg::*;;

  localparam int IDLE_LIMIT = 2000;
  localparam int PROG_LEN   = 24;
  localparam int PHASE_LEN  = 125;

  typedef struct packed {
    logic        present;
    logic [3:0]  kind;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  dr;
    logic [31:0] pc;
    logic [31:0] addr;
  } tick_t;

  typedef enum logic [1:0] {HAZ_NONE, HAZ_STRUCT, HAZ_LOAD_EX, HAZ_LOAD_MEM1} hazard_e;

  // Cycle-level copy of the pipeline; one expected retire slot per request.
  class retire_scoreboard;
    slot_t       stage [STAGE_COUNT];
    logic [1:0]  squash_left;
    bit          squash_on;
    logic [31:0] tag_mem [TABLE_ENTRIES_DEF];
    logic [1:0]  ctr_mem [TABLE_ENTRIES_DEF];
    logic [1:0]  mode;
    result_t     retire_q [$];
    bit          last_taken;
    int          errors;

    function new();
      foreach (stage[i]) stage[i] = vacant(C_BUBBLE);
      foreach (tag_mem[i]) begin
        tag_mem[i] = '0;
        ctr_mem[i] = '0;
      end
      squash_left = '0;
      squash_on   = 1'b0;
      mode        = MODE_NT;
      last_taken  = 1'b0;
      errors      = 0;
    endfunction

    function slot_t vacant(logic [1:0] cls);
      slot_t s;
      s     = '0;
      s.cls = cls;
      s.sa  = NO_REG;
      s.sb  = NO_REG;
      s.dr  = (cls == C_SQUASH) ? 8'd0 : NO_REG;
      return s;
    endfunction

    function bit reads_load_dest(slot_t ld, slot_t dec);
      if (ld.kind != K_LOAD) return 1'b0;
      case (dec.kind)
        K_RTYPE, K_STORE, K_BRANCH: return (ld.dr == dec.sa) || (ld.dr == dec.sb);
        K_ITYPE, K_LOAD, K_JRTYPE:  return ld.dr == dec.sa;
        default:                    return 1'b0;
      endcase
    endfunction

    // Report a misprediction for this branch and, in the one-bit and two-bit modes, update its table entry.
    function bit mispredicted(logic [31:0] baddr, bit taken);
      int unsigned idx;
      bit          hit;
      logic [1:0]  c;
      bit          miss;
      idx  = (baddr >> 3) % TABLE_ENTRIES_DEF;
      hit  = tag_mem[idx] == baddr;
      c    = ctr_mem[idx];
      miss = 1'b0;
      case (mode)
        MODE_NT: miss = taken;
        MODE_ONE: begin
          if (!hit) begin
            tag_mem[idx] = baddr;
            ctr_mem[idx] = {1'b0, taken};
            miss         = taken;
          end else if (c != {1'b0, taken}) begin
            // a counter left at 2 or 3 by the two-bit scheme never matches
            ctr_mem[idx] = {1'b0, taken};
            miss         = 1'b1;
          end
        end
        MODE_TWO: begin
          if (!hit) begin
            tag_mem[idx] = baddr;
            ctr_mem[idx] = taken ? 2'd3 : 2'd0;
            miss         = taken;
          end else begin
            case (c)
              2'd0: if (taken) begin
                ctr_mem[idx] = 2'd1;
                miss         = 1'b1;
              end
              2'd1: begin
                ctr_mem[idx] = taken ? 2'd3 : 2'd0;
                miss         = taken;
              end
              2'd2: begin
                ctr_mem[idx] = taken ? 2'd3 : 2'd0;
                miss         = !taken;
              end
              default: if (!taken) begin
                ctr_mem[idx] = 2'd2;
                miss         = 1'b1;
              end
            endcase
          end
        end
        default: miss = 1'b0;
      endcase
      return miss;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function void note_request(tick_t t);
      slot_t   pend;
      slot_t   wb;
      slot_t   dec;
      hazard_e hz;
      bit      took;
      result_t exp;
      int      i;
      if (t.present) begin
        pend.cls  = C_REAL;
        pend.kind = t.kind;
        pend.sa   = t.sa;
        pend.sb   = t.sb;
        pend.dr   = t.dr;
        pend.pc   = t.pc;
        pend.addr = t.addr;
      end else begin
        pend = vacant(C_BUBBLE);
      end
      if (squash_left == 0) squash_on = 1'b0;

      wb  = stage[ST_WB];
      dec = stage[ST_ID];
      hz  = HAZ_NONE;
      if ((wb.kind == K_RTYPE || wb.kind == K_ITYPE || wb.kind == K_LOAD) &&
          (dec.kind == K_RTYPE || (dec.kind == K_ITYPE && dec.sa != NO_REG) ||
           dec.kind == K_LOAD || dec.kind == K_STORE || dec.kind == K_BRANCH ||
           dec.kind == K_JRTYPE))
        hz = HAZ_STRUCT;
      // load-use wins over the port conflict, MEM1 wins over EX
      if (reads_load_dest(stage[ST_EX], dec)) hz = HAZ_LOAD_EX;
      if (reads_load_dest(stage[ST_MEM1], dec)) hz = HAZ_LOAD_MEM1;

      if (stage[ST_IF1].kind == K_BRANCH &&
          mispredicted(stage[ST_IF1].addr, stage[ST_IF1].addr == pend.pc)) begin
        squash_on   = 1'b1;
        squash_left = SQUASH_SLOTS;
      end

      for (i = ST_WB; i > ST_IF1; i--) begin
        if (i == ST_EX && (hz == HAZ_STRUCT || hz == HAZ_LOAD_EX)) begin
          stage[i] = vacant(C_BUBBLE);
          break;
        end
        if (i == ST_MEM1 && hz == HAZ_LOAD_MEM1) begin
          stage[i] = vacant(C_BUBBLE);
          break;
        end
        stage[i] = stage[i-1];
      end

      took = 1'b0;
      if (squash_on) begin
        // squash fetch replaces IF1 even under a stall
        stage[ST_IF1] = vacant(C_SQUASH);
        if (squash_left != 0) squash_left--;
      end else if (hz == HAZ_NONE) begin
        stage[ST_IF1] = pend;
        took          = t.present;
      end

      exp.slot          = wb;
      exp.pending_taken = took;
      retire_q.push_back(exp);
      last_taken = took;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_retire(result_t got);
      result_t exp;
      if (retire_q.size() == 0) begin
        $error("retire result with no request outstanding: class %0d pc %0h",
               got.slot.cls, got.slot.pc);
        errors++;
        return;
      end
      exp = retire_q.pop_front();
      check_field("retire_class", exp.slot.cls, got.slot.cls);
      check_field("retire_kind", exp.slot.kind, got.slot.kind);
      check_field("retire_src_a", exp.slot.sa, got.slot.sa);
      check_field("retire_src_b", exp.slot.sb, got.slot.sb);
      check_field("retire_dest", exp.slot.dr, got.slot.dr);
      check_field("retire_pc", exp.slot.pc, got.slot.pc);
      check_field("retire_addr", exp.slot.addr, got.slot.addr);
      check_field("pending_taken", exp.pending_taken, got.pending_taken);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  phbp_in_if  in_ch();
  phbp_out_if out_ch();
  phbp_cfg_if cfg_ch();

  pipeline_hazard_branch_predictor_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  retire_scoreboard sb;
  int    requests_seen = 0;
  int    idle_cycles   = 0;

  // program image walked by the sender
  tick_t       prog [PROG_LEN];
  int          prog_target [PROG_LEN];
  int          prog_bias [PROG_LEN];
  int          walk_pos;
  bit          from_program;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    tick_t   seen;
    result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.present = in_ch.pending_valid;
        seen.kind    = in_ch.instr_kind;
        seen.sa      = in_ch.src_reg_a;
        seen.sb      = in_ch.src_reg_b;
        seen.dr      = in_ch.dest_reg;
        seen.pc      = in_ch.instr_pc;
        seen.addr    = in_ch.instr_addr;
        sb.note_request(seen);
        requests_seen++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.slot.cls      = out_ch.retire_class;
        got.slot.kind     = out_ch.retire_kind;
        got.slot.sa       = out_ch.retire_src_a;
        got.slot.sb       = out_ch.retire_src_b;
        got.slot.dr       = out_ch.retire_dest;
        got.slot.pc       = out_ch.retire_pc;
        got.slot.addr     = out_ch.retire_addr;
        got.pending_taken = out_ch.pending_taken;
        sb.check_retire(got);
      end
      if (cfg_ch.valid && cfg_ch.ready) sb.set_mode(cfg_ch.predict_mode);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: stall patterns by segment, plus one long hold-off to back up the block.
  initial begin : receiver
    int seg_len;
    int style;
    int k;
    bit long_done;
    long_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      if (!long_done && requests_seen >= 80) begin
        long_done = 1'b1;
        repeat (150) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end
      seg_len = $urandom_range(5, 40);
      style   = $urandom_range(0, 3);
      for (k = 0; k < seg_len; k++) begin
        @(negedge clk);
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 99) >= 30);
          2:       out_ch.ready <= (k % 3 != 2);
          default: out_ch.ready <= ($urandom_range(0, 99) >= 70);
        endcase
      end
    end
  end

  function automatic tick_t mk(logic present, logic [3:0] kind, logic [7:0] sa,
                               logic [7:0] sb_r, logic [7:0] dr, logic [31:0] pc,
                               logic [31:0] addr);
    tick_t t;
    t.present = present;
    t.kind    = kind;
    t.sa      = sa;
    t.sb      = sb_r;
    t.dr      = dr;
    t.pc      = pc;
    t.addr    = addr;
    return t;
  endfunction

  function automatic tick_t random_tick();
    return mk(1'b1, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom, $urandom);
  endfunction

  function automatic logic [7:0] pick_reg();
    return ($urandom_range(0, 9) == 0) ? NO_REG : 8'($urandom_range(0, 5));
  endfunction

  function automatic void build_program();
    logic [31:0] base;
    int          r;
    base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFA0 : ($urandom & 32'hFFFF_FFFC);
    for (int i = 0; i < PROG_LEN; i++) begin
      r = $urandom_range(0, 99);
      prog[i] = mk(1'b1,
                   r < 20 ? K_RTYPE : r < 35 ? K_ITYPE : r < 52 ? K_LOAD :
                   r < 62 ? K_STORE : r < 80 ? K_BRANCH : r < 85 ? K_NOP :
                   r < 90 ? K_JTYPE : r < 94 ? K_SPEC : K_JRTYPE,
                   pick_reg(), pick_reg(), pick_reg(), base + 32'(4 * i), $urandom);
      prog_target[i] = $urandom_range(0, PROG_LEN - 1);
      case ($urandom_range(0, 4))
        0:       prog_bias[i] = 0;
        1:       prog_bias[i] = 100;
        2:       prog_bias[i] = 90;
        3:       prog_bias[i] = 10;
        default: prog_bias[i] = 50;
      endcase
      if (prog[i].kind == K_BRANCH) prog[i].addr = base + 32'(4 * prog_target[i]);
    end
    walk_pos     = 0;
    from_program = 1'b0;
  endfunction

  // Hold the request until it is accepted; the caller is at a falling edge.
  task automatic drive_tick(tick_t t);
    in_ch.valid         <= 1'b1;
    in_ch.pending_valid <= t.present;
    in_ch.instr_kind    <= t.kind;
    in_ch.src_reg_a     <= t.sa;
    in_ch.src_reg_b     <= t.sb;
    in_ch.dest_reg      <= t.dr;
    in_ch.instr_pc      <= t.pc;
    in_ch.instr_addr    <= t.addr;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Re-present an instruction that did not enter IF1, then drop valid.
  task automatic offer_directed(tick_t t);
    int tries;
    tries = 0;
    forever begin
      @(negedge clk);
      if (tries > 0 && (!t.present || sb.last_taken || tries >= 12)) begin
        in_ch.valid <= 1'b0;
        break;
      end
      drive_tick(t);
      tries++;
    end
  endtask

  task automatic offer_tick();
    tick_t t;
    int    r;
    @(negedge clk);
    // advance the program only once the last fetch made it into IF1
    if (from_program && sb.last_taken) begin
      if (prog[walk_pos].kind == K_BRANCH && $urandom_range(0, 99) < prog_bias[walk_pos])
        walk_pos = prog_target[walk_pos];
      else
        walk_pos = (walk_pos + 1) % PROG_LEN;
    end
    r = $urandom_range(0, 99);
    if (r < 12) begin
      t            = random_tick();
      t.present    = 1'b0;
      from_program = 1'b0;
    end else if (r < 22) begin
      t            = random_tick();
      from_program = 1'b0;
    end else begin
      t            = prog[walk_pos];
      from_program = 1'b1;
    end
    drive_tick(t);
  endtask

  task automatic run_phase(int n_items);
    int sent;
    int burst;
    int gap;
    build_program();
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
      for (int j = 0; j < burst && sent < n_items; j++) begin
        offer_tick();
        sent++;
      end
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_mode(logic [1:0] m);
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.predict_mode <= m;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.retire_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [1:0] phase_modes [6];
    sb                  = new();
    phase_modes         = '{MODE_TWO, MODE_ONE, MODE_NONE, MODE_TWO, MODE_NT, MODE_ONE};
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.pending_valid = 1'b0;
    in_ch.instr_kind    = K_NOP;
    in_ch.src_reg_a     = '0;
    in_ch.src_reg_b     = '0;
    in_ch.dest_reg      = '0;
    in_ch.instr_pc      = '0;
    in_ch.instr_addr    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.predict_mode = MODE_NT;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    write_mode(MODE_NT);
    // bubble fields are ignored even when all ones
    offer_directed(mk(1'b0, 4'hF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    offer_directed(mk(1'b1, K_RTYPE, 8'd0, 8'd0, 8'd0, 32'h0, 32'h0));
    // load-use from EX through the second source
    offer_directed(mk(1'b1, K_LOAD, 8'd1, NO_REG, 8'd3, 32'h4, 32'hFFFF_FFFF));
    offer_directed(mk(1'b1, K_RTYPE, 8'd2, 8'd3, 8'd4, 32'h8, 32'h0));
    // load-use from MEM1 with one slot between
    offer_directed(mk(1'b1, K_LOAD, NO_REG, NO_REG, 8'd7, 32'hC, 32'h0));
    offer_directed(mk(1'b1, K_NOP, NO_REG, NO_REG, NO_REG, 32'h10, 32'h0));
    offer_directed(mk(1'b1, K_STORE, 8'd7, 8'd1, NO_REG, 32'h14, 32'h8000_0000));
    // register-file port conflict with the writer in WB
    offer_directed(mk(1'b1, K_ITYPE, 8'd4, NO_REG, 8'd9, 32'h18, 32'h0));
    offer_directed(mk(1'b1, K_NOP, NO_REG, NO_REG, NO_REG, 32'h1C, 32'h0));
    offer_directed(mk(1'b1, K_NOP, NO_REG, NO_REG, NO_REG, 32'h20, 32'h0));
    offer_directed(mk(1'b1, K_NOP, NO_REG, NO_REG, NO_REG, 32'h24, 32'h0));
    offer_directed(mk(1'b1, K_RTYPE, 8'd9, 8'd9, 8'd10, 32'h28, 32'h0));
    offer_directed(mk(1'b1, K_ITYPE, NO_REG, NO_REG, 8'd11, 32'h2C, 32'h0));
    offer_directed(mk(1'b1, K_JTYPE, NO_REG, NO_REG, NO_REG, 32'h30, 32'h1000));
    offer_directed(mk(1'b1, K_SPEC, NO_REG, NO_REG, NO_REG, 32'h34, 32'h0));
    offer_directed(mk(1'b1, K_JRTYPE, 8'd10, NO_REG, NO_REG, 32'h38, 32'h0));
    // taken branch mispredicted, then a not-taken one
    offer_directed(mk(1'b1, K_BRANCH, 8'd1, 8'd2, NO_REG, 32'h3C, 32'h40));
    offer_directed(mk(1'b1, K_RTYPE, 8'd5, 8'd6, 8'd12, 32'h40, 32'h0));
    offer_directed(mk(1'b1, K_BRANCH, 8'd1, 8'd2, NO_REG, 32'h44, 32'h100));
    offer_directed(mk(1'b1, K_ITYPE, 8'd5, NO_REG, 8'd13, 32'h48, 32'h0));
    // load writing the unused-register code still blocks a reader of it
    offer_directed(mk(1'b1, K_LOAD, 8'd0, NO_REG, NO_REG, 32'h4C, 32'h0));
    offer_directed(mk(1'b1, K_RTYPE, NO_REG, NO_REG, 8'd14, 32'h50, 32'h0));
    offer_directed(mk(1'b1, 4'd9, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFC, 32'hFFFF_FFFF));
    offer_directed(mk(1'b0, K_NOP, 8'd0, 8'd0, 8'd0, 32'h0, 32'h0));
    drain();

    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      run_phase(PHASE_LEN);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.retire_q.size() != 0) begin
      $error("%0d retire results never arrived", sb.retire_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/phbp_pkg.sv
design/phbp_if.sv
design/phbp_ram.sv
design/phbp_cell.sv
design/phbp_pred.sv
design/phbp_oq.sv
design/pipeline_hazard_branch_predictor_core.sv
sim/pipeline_hazard_branch_predictor_core_tb.sv
